// ----- rtl/core/pcb_pkg.sv -----
// ----------------------------------------------------------------------------
// pcb_pkg: shared types and constants for the pixel contrast/brightness block
// Holds stream and register widths, pipeline depth, reciprocal sizing and the
// parameter bundle that the control unit hands to the channel datapaths.
// ----------------------------------------------------------------------------
`default_nettype none

package pcb_pkg;

    // stream geometry
    localparam int CHANNELS   = 3;
    localparam int CHAN_W     = 8;
    localparam int DATA_W     = ((CHANNELS * CHAN_W + 7) / 8) * 8;

    // channel datapath depth, input register to output register
    localparam int PIPE_DEPTH = 7;

    // apb register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_CONTRAST   = 1'b0;
    localparam logic REG_BRIGHTNESS = 1'b1;

    // reciprocal: m = ceil(2^RECIP_SHIFT / d), d in 3..255
    localparam int RECIP_SHIFT = 24;
    localparam int M_W         = 23;
    localparam int DIV_STEPS   = RECIP_SHIFT + 1;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    // percent to 0..255 scale: x/100 == (x*5243) >> 19 for x <= 25500
    localparam int PCT_RECIP       = 5243;
    localparam int PCT_RECIP_SHIFT = 19;

    // derived parameters; the user must keep them stable while beats are in flight, the block does not enforce it
    typedef struct packed {
        logic               ready;
        logic               a_pos;
        logic               a_neg;
        logic               a_full;
        logic signed [8:0]  a;
        logic signed [8:0]  b;
        logic [7:0]         d;
        logic [M_W-1:0]     m;
    } pcb_params_t;

    // saturate a signed sum to 0..255
    function automatic logic [7:0] sat8(input logic signed [9:0] x);
        logic [7:0] res;
        if (x < 0) begin
            res = 8'd0;
        end else if (x > 10'sd255) begin
            res = 8'd255;
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pcb_recip.sv -----
// ----------------------------------------------------------------------------
// pcb_recip: reciprocal of the contrast divisor
// Restoring divider, one quotient bit per cycle, computes
// m = ceil(2^24 / d) = floor((2^24 + d - 1) / d) in DIV_STEPS restoring steps.
// ----------------------------------------------------------------------------
`default_nettype none

module pcb_recip (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [7:0]            d,
    output logic                       done,
    output logic [pcb_pkg::M_W-1:0]    m
);
    import pcb_pkg::*;

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [DIV_STEPS-1:0] num_reg,   num_next;
    logic [7:0]           rem_reg,   rem_next;
    logic [7:0]           d_reg,     d_next;
    logic [M_W-1:0]       quo_reg,   quo_next;

    logic [8:0]           rem_sh;
    logic [8:0]           rem_sub;
    logic                 ge;

    // one restoring step
    always_comb begin
        rem_sh  = {rem_reg, num_reg[DIV_STEPS-1]};
        ge      = (rem_sh >= {1'b0, d_reg});
        rem_sub = rem_sh - {1'b0, d_reg};
    end

    // sequencing
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = (DIV_STEPS'(1) << RECIP_SHIFT) + DIV_STEPS'(d) - DIV_STEPS'(1);
            rem_next  = '0;
            d_next    = d;
            quo_next  = '0;
        end else if (busy_reg) begin
            num_next = {num_reg[DIV_STEPS-2:0], 1'b0};
            rem_next = ge ? rem_sub[7:0] : rem_sh[7:0];
            quo_next = {quo_reg[M_W-2:0], ge};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign m    = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pcb_param.sv -----
// ----------------------------------------------------------------------------
// pcb_param: register file and parameter preparation
// APB register file for contrast and brightness percent; after reset or any
// write it rescales both to -255..255, derives the contrast divisor and runs the
// reciprocal unit, then flags the parameters ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pcb_param (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pcb_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [pcb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pcb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output pcb_pkg::pcb_params_t               prm
);
    import pcb_pkg::*;

    typedef enum logic [3:0] {
        ST_CALC = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_RUN  = 4'b1000
    } pcb_state_t;

    pcb_state_t         state_reg, state_next;
    logic signed [7:0]  contrast_reg, contrast_next;
    logic signed [7:0]  bright_reg,   bright_next;
    logic signed [8:0]  a_reg, a_next;
    logic signed [8:0]  b_reg, b_next;
    logic [7:0]         d_reg, d_next;
    logic               pos_reg, pos_next;
    logic               neg_reg, neg_next;
    logic               full_reg, full_next;
    logic [M_W-1:0]     m_reg, m_next;

    logic               wr_en;
    logic               reg_sel;
    logic               div_start;
    logic               div_done;
    logic [M_W-1:0]     div_m;
    logic signed [7:0]  rd_val;

    // percent to signed -255..255 scale, clamped, truncated toward zero
    function automatic logic signed [8:0] scale_pct(input logic signed [7:0] p);
        logic [6:0]  mag;
        logic        neg;
        logic [14:0] x255;
        logic [27:0] prod;
        logic [7:0]  amag;
        neg = p[7];
        if (p < -8'sd100) begin
            mag = 7'd100;
        end else if (p > 8'sd100) begin
            mag = 7'd100;
        end else if (neg) begin
            mag = 7'(-p);
        end else begin
            mag = p[6:0];
        end
        x255 = {mag, 8'b0} - 15'(mag);
        prod = 28'(x255) * 28'(PCT_RECIP);
        amag = prod[PCT_RECIP_SHIFT+7:PCT_RECIP_SHIFT];
        return neg ? -$signed({1'b0, amag}) : $signed({1'b0, amag});
    endfunction

    // apb access
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign rd_val  = (reg_sel == REG_BRIGHTNESS) ? bright_reg : contrast_reg;
    always_comb begin
        prdata = {{(APB_DATA_W-8){rd_val[7]}}, rd_val};
    end

    always_comb begin
        contrast_next = contrast_reg;
        bright_next   = bright_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_CONTRAST:   contrast_next = pwdata[7:0];
                REG_BRIGHTNESS: bright_next   = pwdata[7:0];
                default:        contrast_next = contrast_reg;
            endcase
        end
    end

    // parameter preparation sequence
    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        pos_next   = pos_reg;
        neg_next   = neg_reg;
        full_next  = full_reg;
        m_next     = m_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_CALC: begin
                a_next     = scale_pct(contrast_reg);
                b_next     = scale_pct(bright_reg);
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                pos_next   = !a_reg[8] && (a_reg != 9'sd0);
                neg_next   = a_reg[8];
                full_next  = (a_reg == 9'sd255);
                d_next     = (!a_reg[8] && (a_reg != 9'sd0) && (a_reg != 9'sd255))
                             ? 8'(9'sd255 - a_reg) : 8'd255;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    m_next     = div_m;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                state_next = ST_RUN;
            end
            default: begin
                state_next = ST_CALC;
            end
        endcase
        if (state_reg == ST_LOAD) begin
            div_start = 1'b1;
        end
        if (wr_en) begin
            state_next = ST_CALC;
        end
    end

    // divisor used by the reciprocal unit comes straight from the load step
    pcb_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .d       (d_next),
        .done    (div_done),
        .m       (div_m)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CALC;
            contrast_reg <= '0;
            bright_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            contrast_reg <= contrast_next;
            bright_reg   <= bright_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        pos_reg  <= pos_next;
        neg_reg  <= neg_next;
        full_reg <= full_next;
        m_reg    <= m_next;
    end

    always_comb begin
        prm.ready  = (state_reg == ST_RUN);
        prm.a_pos  = pos_reg;
        prm.a_neg  = neg_reg;
        prm.a_full = full_reg;
        prm.a      = a_reg;
        prm.b      = b_reg;
        prm.d      = d_reg;
        prm.m      = m_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/core/pcb_chan.sv -----
// ----------------------------------------------------------------------------
// pcb_chan: one color channel of the adjustment pipeline
// Seven register stages: input, brightness pre-add, numerator, reciprocal
// multiply, remainder product, round-to-even, brightness post-add and select.
// ----------------------------------------------------------------------------
`default_nettype none

module pcb_chan (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire pcb_pkg::pcb_params_t prm,
    input  wire logic [7:0]           in_chan,
    output logic [7:0]                out_chan
);
    import pcb_pkg::*;

    logic [7:0]          v1_reg;
    logic [7:0]          w2_reg, w2_next;
    logic signed [17:0]  t3_reg, t3_next;
    logic [7:0]          w3_reg;
    logic [M_W+15:0]     p4_reg, p4_next;
    logic [15:0]         t4_reg;
    logic                neg4_reg;
    logic [7:0]          w4_reg;
    logic [14:0]         q5_reg;
    logic [15:0]         qd5_reg, qd5_next;
    logic [15:0]         t5_reg;
    logic                neg5_reg;
    logic [7:0]          w5_reg;
    logic [7:0]          c6_reg, c6_next;
    logic [7:0]          w6_reg;
    logic [7:0]          out7_reg, out7_next;

    logic signed [9:0]   vb;
    logic signed [17:0]  w255;
    logic signed [8:0]   xw;
    logic signed [17:0]  xa;
    logic signed [17:0]  a_sh;
    logic [22:0]         qd_full;
    logic [15:0]         rem;
    logic [8:0]          rem2;
    logic                up;
    logic [15:0]         qr;
    logic signed [9:0]   cb;

    // brightness first unless contrast is lowered
    always_comb begin
        vb      = $signed({2'b00, v1_reg}) + $signed({prm.b[8], prm.b});
        w2_next = prm.a_neg ? v1_reg : sat8(vb);
    end

    // numerator t = w*d + (w-128)*a
    always_comb begin
        w255    = $signed({2'b00, w2_reg, 8'b0}) - $signed({10'b0, w2_reg});
        xw      = $signed({1'b0, w2_reg}) - 9'sd128;
        xa      = xw * prm.a;
        a_sh    = $signed({{2{prm.a[8]}}, prm.a, 7'b0});
        t3_next = prm.a_pos ? (w255 - a_sh) : (w255 + xa);
    end

    // quotient estimate through the reciprocal
    always_comb begin
        p4_next = (M_W+16)'(t3_reg[15:0]) * (M_W+16)'(prm.m);
    end

    // quotient times divisor for the remainder
    always_comb begin
        qd_full  = 23'(p4_reg[M_W+15:RECIP_SHIFT]) * 23'(prm.d);
        qd5_next = qd_full[15:0];
    end

    // round half to even, then saturate; negative numerators give zero
    always_comb begin
        rem  = t5_reg - qd5_reg;
        rem2 = {rem[7:0], 1'b0};
        up   = (rem2 > {1'b0, prm.d}) || ((rem2 == {1'b0, prm.d}) && q5_reg[0]);
        qr   = {1'b0, q5_reg} + 16'(up);
        if (neg5_reg) begin
            c6_next = 8'd0;
        end else if (qr > 16'd255) begin
            c6_next = 8'd255;
        end else begin
            c6_next = qr[7:0];
        end
    end

    // mode select and brightness post-add
    always_comb begin
        cb = $signed({2'b00, c6_reg}) + $signed({prm.b[8], prm.b});
        if (prm.a_full) begin
            out7_next = w6_reg[7] ? 8'd255 : 8'd0;
        end else if (prm.a_pos) begin
            out7_next = c6_reg;
        end else if (prm.a_neg) begin
            out7_next = sat8(cb);
        end else begin
            out7_next = w6_reg;
        end
    end

    // pipeline registers advance together
    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg   <= in_chan;
            w2_reg   <= w2_next;
            t3_reg   <= t3_next;
            w3_reg   <= w2_reg;
            p4_reg   <= p4_next;
            t4_reg   <= t3_reg[15:0];
            neg4_reg <= t3_reg[17];
            w4_reg   <= w3_reg;
            q5_reg   <= p4_reg[M_W+15:RECIP_SHIFT];
            qd5_reg  <= qd5_next;
            t5_reg   <= t4_reg;
            neg5_reg <= neg4_reg;
            w5_reg   <= w4_reg;
            c6_reg   <= c6_next;
            w6_reg   <= w5_reg;
            out7_reg <= out7_next;
        end
    end

    assign out_chan = out7_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pixel_contrast_brightness_top.sv -----
// ----------------------------------------------------------------------------
// pixel_contrast_brightness_top: per-pixel brightness and contrast adjustment
// Input pixels arrive on the s_ stream, adjusted pixels leave on the m_ stream.
// Contrast and brightness percent are set through the APB port: contrast at
// byte address 0, brightness at byte address 4, both 8-bit signed.
// One beat per cycle is accepted while the parameters are ready and the output
// register is empty or being taken; every pixel passes through the seven
// register stages of the channel datapath.
// When the receiver stalls, the whole pipeline holds and s_tready drops; no
// beat is lost or repeated.
// After reset, and after each register write, s_tready stays low while the
// percentages are rescaled and the contrast divisor reciprocal is computed by
// a one-bit-per-cycle divider (25 steps).
// Reset clears the registers to zero percent, which passes pixels unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_contrast_brightness_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // apb register port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pcb_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [pcb_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pcb_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // pixel in
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pcb_pkg::DATA_W-1:0]     s_tdata,  // in_chan0, in_chan1, in_chan2
    // pixel out
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pcb_pkg::DATA_W-1:0]          m_tdata   // out_chan0, out_chan1, out_chan2
);
    import pcb_pkg::*;

    pcb_params_t            prm;
    logic                   advance;
    logic [PIPE_DEPTH-1:0]  vld_reg, vld_next;
    logic [CHANNELS*CHAN_W-1:0] out_bits;

    // registers and derived parameters
    pcb_param u_param (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .prm     (prm)
    );

    // global pipeline advance, held while the output beat waits
    assign advance  = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = advance && prm.ready;

    always_comb begin
        vld_next = vld_reg;
        if (advance) begin
            vld_next = {vld_reg[PIPE_DEPTH-2:0], s_tvalid && s_tready};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // one datapath per channel
    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        pcb_chan u_chan (
            .aclk     (aclk),
            .en       (advance),
            .prm      (prm),
            .in_chan  (s_tdata[g*CHAN_W +: CHAN_W]),
            .out_chan (out_bits[g*CHAN_W +: CHAN_W])
        );
    end

    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_tdata  = DATA_W'(out_bits);

endmodule

`default_nettype wire

// ----- test/pixel_contrast_brightness_checker.sv -----
// ----------------------------------------------------------------------------
// pixel_contrast_brightness_checker: scoreboard for the contrast/brightness top
// Watches the APB writes and both pixel streams. It keeps its own copy of the
// two percent registers, predicts every adjusted pixel when its input beat is
// taken, and compares each output beat channel by channel, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_contrast_brightness_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pcb_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [pcb_pkg::APB_DATA_W-1:0] pwdata,
    input  wire logic                           pready,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [pcb_pkg::DATA_W-1:0]     s_tdata,  // in_chan0, in_chan1, in_chan2
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [pcb_pkg::DATA_W-1:0]     m_tdata,  // out_chan0, out_chan1, out_chan2
    output int                                  errors,
    output int                                  pending
);

    import pcb_pkg::*;

    localparam int NCH = CHANNELS;

    logic signed [7:0] contrast_pct;
    logic signed [7:0] brightness_pct;
    logic [DATA_W-1:0] pixel_q [$];

    // percent, limited to +-100, scaled to -255..255 with truncation
    function automatic int pct_to_level(input logic signed [7:0] p);
        int x;
        x = p;
        if (x < -100) begin
            x = -100;
        end else if (x > 100) begin
            x = 100;
        end
        return x * 255 / 100;
    endfunction

    function automatic int clip8(input int x);
        int res;
        if (x < 0) begin
            res = 0;
        end else if (x > 255) begin
            res = 255;
        end else begin
            res = x;
        end
        return res;
    endfunction

    // v + num/den rounded to nearest, ties to even, then clipped
    function automatic int stretch_round(input int v, input int num, input int den);
        int t;
        int q;
        int r;
        t = v * den + num;
        q = t / den;
        r = t % den;
        if (r < 0) begin
            r = r + den;
            q = q - 1;
        end
        if (2 * r > den || (2 * r == den && q[0])) begin
            q = q + 1;
        end
        return clip8(q);
    endfunction

    function automatic int adjust_level(input int v, input int a, input int b);
        int w;
        int res;
        if (a > 0) begin
            // brightness first, then stretch or hard threshold
            w = clip8(v + b);
            if (a == 255) begin
                res = (w >= 128) ? 255 : 0;
            end else begin
                res = stretch_round(w, (w - 128) * a, 255 - a);
            end
        end else if (a < 0) begin
            // flatten toward mid gray, then brightness
            w = stretch_round(v, (v - 128) * a, 255);
            res = clip8(w + b);
        end else begin
            res = clip8(v + b);
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] adjusted_pixel(input logic [DATA_W-1:0] px,
                                                         input logic signed [7:0] c_pct,
                                                         input logic signed [7:0] k_pct);
        logic [DATA_W-1:0] res;
        int a;
        int b;
        int lvl;
        res = '0;
        a = pct_to_level(c_pct);
        b = pct_to_level(k_pct);
        for (int i = 0; i < NCH; i++) begin
            lvl = adjust_level(int'(px[i*CHAN_W +: CHAN_W]), a, b);
            res[i*CHAN_W +: CHAN_W] = CHAN_W'(lvl);
        end
        return res;
    endfunction

    // register shadow, prediction on input beats, comparison on output beats
    always @(posedge aclk) begin
        logic [DATA_W-1:0] want;
        int bad;
        if (!aresetn) begin
            contrast_pct   = '0;
            brightness_pct = '0;
            pixel_q.delete();
            errors  <= 0;
            pending <= 0;
        end else begin
            bad = 0;
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    REG_CONTRAST:   contrast_pct   = pwdata[7:0];
                    REG_BRIGHTNESS: brightness_pct = pwdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                pixel_q.push_back(adjusted_pixel(s_tdata, contrast_pct, brightness_pct));
            end
            if (m_tvalid && m_tready) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: output beat %h with no pixel expected", $time, m_tdata);
                    bad = 1;
                end else begin
                    want = pixel_q.pop_front();
                    for (int i = 0; i < NCH; i++) begin
                        if (m_tdata[i*CHAN_W +: CHAN_W] !== want[i*CHAN_W +: CHAN_W]) begin
                            $display("%0t: out_chan%0d mismatch, expected %0d actual %0d",
                                     $time, i, want[i*CHAN_W +: CHAN_W],
                                     m_tdata[i*CHAN_W +: CHAN_W]);
                            bad = 1;
                        end
                    end
                end
            end
            errors  <= errors + bad;
            pending <= pixel_q.size();
        end
    end

endmodule

`default_nettype wire

// ----- test/pixel_contrast_brightness_top_tb.sv -----
// ----------------------------------------------------------------------------
// pixel_contrast_brightness_top_tb: stream test of the contrast/brightness top
// Writes contrast and brightness settings over APB while the block is idle,
// sends directed pixels for the corner cases and then random pixels under
// many settings, with random gaps on the sender and stalls on the receiver.
// The checker predicts and compares every output pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_contrast_brightness_top_tb;

    import pcb_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RAND_PHASES    = 16;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata  = '0;  // in_chan0, in_chan1, in_chan2
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;        // out_chan0, out_chan1, out_chan2

    int errors;
    int pending;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;

    always #4 aclk = ~aclk;

    pixel_contrast_brightness_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pixel_contrast_brightness_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        int res;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            res = 0;
        end else if (r < 92) begin
            res = $urandom_range(1, 3);
        end else begin
            res = $urandom_range(8, 40);
        end
        return res;
    endfunction

    // receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!rx_idle || $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b1;
        end else begin
            stall_left <= gap_len();
            m_tready   <= 1'b0;
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("pixel_contrast_brightness_top test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        do @(posedge aclk); while (pending != 0);
    endtask

    // one apb write: setup cycle, then access until pready
    task automatic reg_write(input logic idx, input logic signed [7:0] pct);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_W-8){pct[7]}}, pct};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // settings change only once the pipeline is empty
    task automatic set_levels(input logic signed [7:0] c_pct, input logic signed [7:0] k_pct);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (PIPE_DEPTH + 1) @(posedge aclk);
        reg_write(REG_CONTRAST, c_pct);
        reg_write(REG_BRIGHTNESS, k_pct);
    endtask

    task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
        int gap;
        gap = tx_idle ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c2, c1, c0};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic signed [7:0] pick_pct();
        logic signed [7:0] res;
        case ($urandom_range(0, 9))
            0: res = -8'sd100;
            1: res = 8'sd100;
            2: res = -8'sd128;
            3: res = 8'sd127;
            4: res = $urandom_range(0, 1) ? 8'sd101 : -8'sd101;
            5: res = 8'sd0;
            default: res = 8'($urandom_range(0, 255));
        endcase
        return res;
    endfunction

    function automatic logic [7:0] pick_level(input int mode);
        logic [7:0] res;
        case (mode)
            0: res = 8'(128 + $urandom_range(0, 8) - 4);
            1: res = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
                                          : 8'(255 - $urandom_range(0, 3));
            default: res = 8'($urandom_range(0, 255));
        endcase
        return res;
    endfunction

    initial begin
        int n_items;
        int mode;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings pass pixels through
        send_pixel(8'd0, 8'd255, 8'd128);
        send_pixel(8'd127, 8'd1, 8'd254);
        send_pixel(8'hAA, 8'h55, 8'hFF);

        // full contrast, hard threshold at mid gray
        set_levels(8'sd100, 8'sd0);
        send_pixel(8'd127, 8'd128, 8'd255);
        send_pixel(8'd0, 8'd129, 8'd126);
        set_levels(8'sd100, 8'sd50);
        send_pixel(8'd0, 8'd1, 8'd128);

        // small contrast with an even divisor, exact half-way ties
        set_levels(8'sd2, 8'sd0);
        send_pixel(8'd153, 8'd103, 8'd203);
        send_pixel(8'd178, 8'd128, 8'd0);

        // strongest stretch short of the threshold
        set_levels(8'sd99, -8'sd1);
        send_pixel(8'd126, 8'd130, 8'd128);

        // flattened contrast with full brightness either way
        set_levels(-8'sd100, 8'sd100);
        send_pixel(8'd0, 8'd255, 8'd128);
        set_levels(-8'sd50, -8'sd100);
        send_pixel(8'd255, 8'd200, 8'd0);
        send_pixel(8'd64, 8'd191, 8'd127);

        // percentages beyond the legal range saturate
        set_levels(8'sd127, -8'sd128);
        send_pixel(8'd255, 8'd200, 8'd128);
        set_levels(-8'sd128, 8'sd127);
        send_pixel(8'd0, 8'd50, 8'd128);
        set_levels(8'sd101, -8'sd101);
        send_pixel(8'd128, 8'd255, 8'd100);
        set_levels(-8'sd101, 8'sd101);
        send_pixel(8'd1, 8'd127, 8'd250);

        // random settings, each with a burst of random pixels
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_levels(pick_pct(), pick_pct());
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            n_items = $urandom_range(60, 140);
            for (int i = 0; i < n_items; i++) begin
                mode = $urandom_range(0, 9);
                send_pixel(pick_level(mode), pick_level(mode), pick_level(mode));
            end
        end

        // drain and settle
        s_tvalid <= 1'b0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("pixel_contrast_brightness_top test passed");
        end else begin
            $display("pixel_contrast_brightness_top test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/pcb_pkg.sv
rtl/core/pcb_recip.sv
rtl/core/pcb_param.sv
rtl/core/pcb_chan.sv
rtl/core/pixel_contrast_brightness_top.sv
test/pixel_contrast_brightness_checker.sv
test/pixel_contrast_brightness_top_tb.sv
